[sv/pbsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_pkg
// Shared types, character codes and base classification for the pileup
// base string parser.
// ----------------------------------------------------------------------------
package pbsp_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;
  localparam logic [2:0] BASE_N = 3'd4;

  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_CARET  = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } class_t;

  typedef struct packed {
    logic        line_done;
    logic [15:0] bases_so_far;
    logic [2:0]  base_code;
    logic        base_valid;
  } res_t;

  function automatic class_t pbsp_classify(input logic [7:0] c, input logic [2:0] ref_code);
    class_t r;
    r.hit  = 1'b1;
    r.code = BASE_A;
    unique case (c)
      CH_DOT, CH_COMMA: r.code = (ref_code > BASE_N) ? BASE_N : ref_code;
      8'h41, 8'h61:     r.code = BASE_A;
      8'h43, 8'h63:     r.code = BASE_C;
      8'h47, 8'h67:     r.code = BASE_G;
      8'h54, 8'h74:     r.code = BASE_T;
      8'h4E, 8'h6E, CH_STAR, CH_LT, CH_GT: r.code = BASE_N;
      default:          r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[sv/pbsp_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_step
// Next-state and result logic for one character of the read-base string.
// ----------------------------------------------------------------------------
module pbsp_step
  import pbsp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic [7:0]             pileup_char,
  input  logic [2:0]             ref_nt,
  input  logic                   line_last,
  input  phase_t                 phase,
  input  logic [COUNT_WIDTH-1:0] skip,
  input  logic [COUNT_WIDTH-1:0] cnt,
  output phase_t                 phase_next,
  output logic [COUNT_WIDTH-1:0] skip_next,
  output logic [COUNT_WIDTH-1:0] cnt_next,
  output res_t                   res
);

  localparam int W = COUNT_WIDTH;

  logic           is_digit;
  logic [7:0]     digit;
  logic [W+3:0]   acc;
  logic [W-1:0]   skip_sat;
  logic [W-1:0]   skip_dec;
  logic           skip_zero;
  class_t         cls;
  logic           valid;
  logic [2:0]     code;
  phase_t         ph;
  logic [W-1:0]   sk;
  logic [W-1:0]   cnt_upd;
  logic [W+15:0]  cnt_ext;

  assign is_digit  = (pileup_char >= CH_ZERO) && (pileup_char <= CH_NINE);
  assign digit     = pileup_char - CH_ZERO;
  // skip * 10 + digit, saturating
  assign acc       = {1'b0, skip, 3'b000} + {3'b000, skip, 1'b0}
                   + {{W{1'b0}}, digit[3:0]};
  assign skip_sat  = (|acc[W+3:W]) ? {W{1'b1}} : acc[W-1:0];
  assign skip_dec  = skip - {{(W-1){1'b0}}, 1'b1};
  assign skip_zero = (skip == '0);
  assign cls       = pbsp_classify(pileup_char, ref_nt);

  always_comb begin
    ph    = phase;
    sk    = skip;
    valid = 1'b0;
    code  = BASE_A;
    unique case (phase)
      PH_CARET: begin
        ph = PH_NORMAL;
      end
      PH_DIGITS: begin
        if (is_digit) begin
          sk = skip_sat;
        end else if (!skip_zero) begin
          sk = skip_dec;
          ph = (skip_dec == '0) ? PH_NORMAL : PH_SKIP;
        end else begin
          ph = PH_NORMAL;
        end
      end
      PH_SKIP: begin
        if (!skip_zero) begin
          sk = skip_dec;
        end
        if (skip_zero || (skip_dec == '0)) begin
          ph = PH_NORMAL;
        end
      end
      default: begin
        ph = PH_NORMAL;
      end
    endcase
    // normal-phase parse, also reached after an empty indel length
    if ((phase == PH_NORMAL) || ((phase == PH_DIGITS) && !is_digit && skip_zero)) begin
      if (pileup_char == CH_CARET) begin
        ph = PH_CARET;
      end else if ((pileup_char == CH_PLUS) || (pileup_char == CH_MINUS)) begin
        ph = PH_DIGITS;
        sk = '0;
      end else begin
        valid = cls.hit;
        code  = cls.code;
      end
    end
  end

  assign cnt_upd = (valid && (cnt != {W{1'b1}})) ? cnt + {{(W-1){1'b0}}, 1'b1} : cnt;
  assign cnt_ext = {16'b0, cnt_upd};

  assign phase_next = line_last ? PH_NORMAL : ph;
  assign skip_next  = line_last ? '0 : sk;
  assign cnt_next   = line_last ? '0 : cnt_upd;

  assign res.base_valid   = valid;
  assign res.base_code    = valid ? code : BASE_A;
  assign res.bases_so_far = cnt_ext[15:0];
  assign res.line_done    = line_last;

endmodule

[sv/pbsp_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsp_out_buf
// Result register with a skid entry; ready toward the source is registered.
// ----------------------------------------------------------------------------
module pbsp_out_buf
  import pbsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic out_full;
  logic skid_valid;
  res_t skid_res;
  logic in_fire;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_full || out_ready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_full   <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_fire) begin
        out_res  <= in_res;
        out_full <= 1'b1;
      end else begin
        out_full <= 1'b0;
      end
    end else if (in_fire) begin
      skid_res   <= in_res;
      skid_valid <= 1'b1;
    end
  end

endmodule

[sv/pileup_base_string_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_base_string_parser
// Turns the read-base column of a pileup line into clean base codes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per item with the line's reference base;
//   s_axis_tlast marks the last character of a line. m_axis returns exactly
//   one item per character: tuser flags a base, tdata holds the base code and
//   the running per-line base count, tlast echoes the end-of-line mark.
//   Accepted items are registered into the output stage or, on a stall,
//   the skid entry. Throughput is one item per cycle while m_axis accepts;
//   the accept cycle updates parse state via a single level of compare/add logic.
//   Reset clears the parse state and count and empties the output stage.
//   When m_axis stalls, one further item is held in a skid entry, then
//   s_axis_tready drops (registered) until the output drains.
//   An end-of-line item abandons any pending skip and clears the count.
// ----------------------------------------------------------------------------
module pileup_base_string_parser
  import pbsp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] pileup_char, [10:8] reference base, [15:11] zero
  input  logic        s_axis_tlast,   // line_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] base_code, [18:3] bases_so_far, [23:19] zero
  output logic        m_axis_tuser,   // base_valid
  output logic        m_axis_tlast    // line_done
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [COUNT_WIDTH-1:0] skip;
  logic [COUNT_WIDTH-1:0] skip_next;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_next;
  res_t                   res;
  res_t                   out_res;
  logic                   s_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;

  pbsp_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .pileup_char(s_axis_tdata[7:0]),
    .ref_nt     (s_axis_tdata[10:8]),
    .line_last  (s_axis_tlast),
    .phase      (phase),
    .skip       (skip),
    .cnt        (cnt),
    .phase_next (phase_next),
    .skip_next  (skip_next),
    .cnt_next   (cnt_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NORMAL;
      skip  <= '0;
      cnt   <= '0;
    end else if (s_fire) begin
      phase <= phase_next;
      skip  <= skip_next;
      cnt   <= cnt_next;
    end
  end

  pbsp_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_res   (res),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.bases_so_far, out_res.base_code};
  assign m_axis_tuser = out_res.base_valid;
  assign m_axis_tlast = out_res.line_done;

`ifndef SYNTH
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output stage");

  a_no_base_zero_code: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[2:0] == BASE_A))
    else $error("base code set without a base");

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_axis_tlast) |=> (phase == PH_NORMAL && skip == '0 && cnt == '0))
    else $error("state not cleared after end of line");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (skip != '0))
    else $error("skip phase with zero count");
`endif

endmodule

[test/tb_pileup_base_string_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pileup_base_string_parser
// Self-checking bench for the pileup base string parser. A tracker of the
// parse state predicts every output item. Directed lines, indel length
// saturation, a long line and back-pressure run first; random well-formed
// pileup lines mixed with noise then run under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_pileup_base_string_parser;
  import pbsp_pkg::*;

  localparam logic [15:0] CNT_MAX   = 16'hFFFF;
  localparam int          CYC_LIMIT = 600000;
  localparam logic [7:0]  CH_DOLLAR = 8'h24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] pileup_char, [10:8] reference base, [15:11] zero
  logic        s_axis_tlast = 1'b0; // line_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [2:0] base_code, [18:3] bases_so_far, [23:19] zero
  logic        m_axis_tuser;        // base_valid
  logic        m_axis_tlast;        // line_done

  pileup_base_string_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // parse state tracker
  phase_t      trk_phase = PH_NORMAL;
  logic [15:0] trk_skip  = '0;
  logic [15:0] trk_count = '0;

  res_t exp_base_q[$];
  int   fail_count = 0;
  int   items_sent = 0;
  int   cycle_cnt  = 0;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   hold_len   = 0;
  int   hold_token = 0;
  int   hold_seen  = 0;
  int   hold_cnt   = 0;

  function automatic void scan_normal(input logic [7:0] c, input logic [2:0] rb,
                                      output logic hit, output logic [2:0] code);
    hit  = 1'b0;
    code = BASE_A;
    if (c == CH_CARET) begin
      trk_phase = PH_CARET;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      trk_phase = PH_DIGITS;
      trk_skip  = '0;
    end else begin
      hit = 1'b1;
      case (c)
        CH_DOT, CH_COMMA: code = (rb > BASE_N) ? BASE_N : rb;
        "A", "a": code = BASE_A;
        "C", "c": code = BASE_C;
        "G", "g": code = BASE_G;
        "T", "t": code = BASE_T;
        "N", "n", CH_STAR, CH_LT, CH_GT: code = BASE_N;
        default: hit = 1'b0;
      endcase
    end
  endfunction

  function automatic res_t predict_base(input logic [7:0] c, input logic [2:0] rb,
                                        input logic last);
    res_t        r;
    logic        hit;
    logic [2:0]  code;
    logic [31:0] acc;
    hit  = 1'b0;
    code = BASE_A;
    case (trk_phase)
      PH_CARET: trk_phase = PH_NORMAL;
      PH_DIGITS: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          acc = trk_skip;
          acc = acc * 10 + (c - CH_ZERO);
          trk_skip = (acc > CNT_MAX) ? CNT_MAX : acc[15:0];
        end else if (trk_skip == 0) begin
          trk_phase = PH_NORMAL;
          scan_normal(c, rb, hit, code);
        end else begin
          trk_skip  = trk_skip - 1'b1;
          trk_phase = (trk_skip == 0) ? PH_NORMAL : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (trk_skip != 0) trk_skip = trk_skip - 1'b1;
        if (trk_skip == 0) trk_phase = PH_NORMAL;
      end
      default: begin
        trk_phase = PH_NORMAL;
        scan_normal(c, rb, hit, code);
      end
    endcase
    if (hit && trk_count != CNT_MAX) trk_count = trk_count + 1'b1;
    r.base_valid   = hit;
    r.base_code    = hit ? code : BASE_A;
    r.bases_so_far = trk_count;
    r.line_done    = last;
    if (last) begin
      trk_phase = PH_NORMAL;
      trk_skip  = '0;
      trk_count = '0;
    end
    return r;
  endfunction

  // prediction on input accept, comparison on output accept
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        exp_base_q = {exp_base_q,
                      predict_base(s_axis_tdata[7:0], s_axis_tdata[10:8], s_axis_tlast)};
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_base_q.size() == 0) begin
          $error("unexpected output item: tdata %h tuser %b tlast %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count++;
        end else begin
          want = exp_base_q.pop_front();
          if (m_axis_tuser !== want.base_valid) begin
            $error("base_valid: expected %0d, got %0d", want.base_valid, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[2:0] !== want.base_code) begin
            $error("base_code: expected %0d, got %0d", want.base_code, m_axis_tdata[2:0]);
            fail_count++;
          end
          if (m_axis_tdata[18:3] !== want.bases_so_far) begin
            $error("bases_so_far: expected %0d, got %0d", want.bases_so_far,
                   m_axis_tdata[18:3]);
            fail_count++;
          end
          if (m_axis_tdata[23:19] !== 5'd0) begin
            $error("tdata pad: expected 0, got %0d", m_axis_tdata[23:19]);
            fail_count++;
          end
          if (m_axis_tlast !== want.line_done) begin
            $error("line_done: expected %0d, got %0d", want.line_done, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_cnt      <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] c, input logic [2:0] rb, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, rb, c};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_line(input string s, input logic [2:0] rb);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], rb, i == s.len() - 1);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (exp_base_q.size() != 0);
  endtask

  task automatic send_random_line();
    string      bases;
    string      digits;
    logic [7:0] chars[$];
    logic [2:0] rb;
    int         len;
    bases = "ACGTNacgtn.,*<>";
    rb = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    repeat ($urandom_range(1, 30)) begin
      case ($urandom_range(19))
        0, 1: begin
          chars = {chars, CH_CARET};
          chars = {chars, 8'($urandom_range(33, 126))};
        end
        2: chars = {chars, CH_DOLLAR};
        3, 4: begin
          chars = {chars, ($urandom_range(1) ? CH_PLUS : CH_MINUS)};
          len = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12);
          digits = $sformatf("%0d", len);
          if ($urandom_range(7) == 0) digits = {"0", digits};
          if ($urandom_range(9) != 0)
            for (int i = 0; i < digits.len(); i++) chars = {chars, digits[i]};
          if ($urandom_range(7) == 0) len = len + $urandom_range(2) - 1;
          for (int i = 0; i < len; i++)
            chars = {chars, bases[$urandom_range(9)]};
        end
        5: chars = {chars, 8'($urandom_range(255))};
        default: chars = {chars, bases[$urandom_range(bases.len() - 1)]};
      endcase
    end
    for (int i = 0; i < chars.size(); i++)
      send_item(chars[i], rb, i == chars.size() - 1);
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(8'h00, 3'd7, 1'b0);
    send_item(8'hFF, 3'd7, 1'b0);
    send_line(".,AcGtn*<>$", 3'd7);
    send_line("^!+0C-g+2AAT^", 3'd0);
    wait_results_drained();
  endtask

  task automatic test_indel_limits();
    send_line("+99999AC", 3'd3);
    send_line(".a", 3'd1);
    send_line("+3", 3'd2);
    send_line("-12", 3'd4);
    wait_results_drained();
  endtask

  task automatic test_long_line();
    idle_pct  = 0;
    stall_pct = 0;
    repeat (60) send_item("a", 3'd2, 1'b0);
    send_item(CH_COMMA, 3'd2, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    int start;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_len   = 300;
    hold_token = hold_token + 1;
    start      = items_sent;
    while (items_sent - start < 40) send_random_line();
    wait_results_drained();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = items_sent;
    while (items_sent - start < n) send_random_line();
    wait_results_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_indel_limits();
    test_long_line();
    test_backpressure();
    test_random(290, 0, 0);
    test_random(290, 61, 0);
    test_random(290, 0, 61);
    test_random(290, 18, 18);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && exp_base_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
sv/pbsp_pkg.sv
sv/pbsp_step.sv
sv/pbsp_out_buf.sv
sv/pileup_base_string_parser.sv
test/tb_pileup_base_string_parser.sv
